@@ rtl/prb_pkg.sv @@
package prb_pkg;

    // Operation codes carried by the operation field
    typedef enum logic [1:0] {
        OP_RESTART  = 2'd0,
        OP_RAW      = 2'd1,
        OP_BOUNDED  = 2'd2,
        OP_INTERVAL = 2'd3
    } op_t;

    // Multiplier operand selection (32x32 partial products of the 64-bit LCG multiply)
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_LL,
        MUL_LH,
        MUL_HL
    } mul_sel_t;

    // Accumulator operation
    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_INIT,
        ACC_ADD_HI
    } acc_op_t;

    // Generator state update
    typedef enum logic [1:0] {
        SOP_NONE,
        SOP_ZERO,
        SOP_ADD_SEED,
        SOP_LOAD_ACC
    } st_op_t;

    // Divider operand source
    typedef enum logic {
        DIV_FLOOR,
        DIV_DRAW
    } div_src_t;

    // Result selection
    typedef enum logic [1:0] {
        OUT_ZERO,
        OUT_RAW,
        OUT_LOW,
        OUT_REM
    } out_sel_t;

    // What follows the end of a state advance
    typedef enum logic [1:0] {
        PH_RST1,
        PH_RST2,
        PH_RAW,
        PH_DRAW
    } phase_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SEED,
        S_ADV0,
        S_ADV1,
        S_ADV2,
        S_ADV3,
        S_ADV4,
        S_FLOOR_WAIT,
        S_CHECK,
        S_MOD_WAIT,
        S_FINISH
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic     load_in;
        mul_sel_t mul_sel;
        acc_op_t  acc_op;
        st_op_t   st_op;
        logic     capture_r;
        logic     div_start;
        div_src_t div_src;
        logic     load_floor;
        logic     load_out;
        out_sel_t out_sel;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        op_t  op;
        logic bound_zero;
        logic interval_empty;
        logic reject;
        logic div_busy;
        logic div_done;
    } status_t;

    // Rejection sampling gives up after this try index
    localparam logic [5:0] TRY_LAST = 6'd63;

    // Configuration register map (64-bit registers at 8-byte spacing)
    localparam int unsigned CFG_ADDR_W = 5;
    localparam logic [1:0]  CFG_MULT   = 2'd0;
    localparam logic [1:0]  CFG_INC    = 2'd1;
    localparam logic [1:0]  CFG_SEED   = 2'd2;

    // Reset values
    localparam logic [63:0] MULT_RESET = 64'd6364136223846793005;
    localparam logic [63:0] INC_RESET  = 64'd1442695040888963407;
    localparam logic [63:0] SEED_RESET = 64'd69420;

    // State after the seeding sequence with the reset constants:
    // 0 -> inc -> inc + seed -> (inc + seed) * mult + inc
    localparam logic [63:0] STATE_RESET = (INC_RESET + SEED_RESET) * MULT_RESET + INC_RESET;

endpackage

@@ rtl/pcg32_bounded_random_source.sv @@
// PCG32 XSH-RR random source with raw, bounded and interval draws.
//
// Input channel (in_valid / in_stall): one transaction carries operation,
// range_low and range_high; it is accepted when in_valid is high and
// in_stall is low. The block takes one transaction at a time.
// Output channel (out_valid / out_stall): exactly one random_value per input
// transaction, in order. The result sits in an output register; while the
// receiver stalls it holds, and the block may already accept the next input,
// finishing its work and then waiting until the register is free.
// Trivial cases skip the multiplier and the divider; a bounded or interval
// draw repeats the state advance for each rejected try. The state advance
// runs on one shared 32x32 multiplier; each modulo runs on a bit-serial
// divider, and a bounded draw needs two of them. The next transaction is
// accepted in the cycle after the result is loaded, so transactions do not
// overlap.
// Configuration: APB-style port, 64-bit registers at byte addresses 0
// (multiplier), 8 (increment) and 16 (seed); write only while idle.
// Reset: registers take the standard constants and seed 69420, and the
// generator state is already seeded; the block is ready right after reset.
module pcg32_bounded_random_source
    import prb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            operation,
    input  logic [31:0]           range_low,
    input  logic [31:0]           range_high,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [31:0]           random_value,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    logic [63:0] mult_reg;
    logic [63:0] inc_reg;
    logic [63:0] seed_reg;
    logic [1:0]  cfg_idx;
    logic        cfg_wr;
    cmd_t        cmd;
    status_t     status;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= MULT_RESET;
            inc_reg  <= INC_RESET;
            seed_reg <= SEED_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                CFG_MULT: mult_reg <= pwdata;
                CFG_INC:  inc_reg  <= pwdata;
                CFG_SEED: seed_reg <= pwdata;
                default:  ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        case (cfg_idx)
            CFG_MULT: prdata = mult_reg;
            CFG_INC:  prdata = inc_reg;
            CFG_SEED: prdata = seed_reg;
            default:  prdata = '0;
        endcase
    end

    prb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    prb_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .operation      (operation),
        .range_low      (range_low),
        .range_high     (range_high),
        .lcg_multiplier (mult_reg),
        .lcg_increment  (inc_reg),
        .seed_value     (seed_reg),
        .random_value   (random_value)
    );

endmodule

@@ rtl/prb_div.sv @@
module prb_div
    import prb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] remainder
);

    localparam logic [5:0] DIV_STEPS = 6'd32;

    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvd_reg;
    logic [31:0] dvs_reg;

    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] diff;
    logic [31:0] rem_next;

    // One restoring step: shift in a dividend bit, subtract when it fits
    assign rem_sh   = {rem_reg, dvd_reg[31]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign diff     = rem_sh - {1'b0, dvs_reg};
    assign rem_next = ge ? diff[31:0] : rem_sh[31:0];

    // Step counter and completion pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_STEPS;
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 6'd1;
            done_reg <= (cnt_reg == 6'd1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Operand and partial remainder registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[30:0], 1'b0};
        end
    end

    assign busy      = (cnt_reg != '0);
    assign done      = done_reg;
    assign remainder = rem_reg;

    // Completion only follows a running division
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("divider done without a running division");

endmodule

@@ rtl/prb_datapath.sv @@
module prb_datapath
    import prb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [1:0]  operation,
    input  logic [31:0] range_low,
    input  logic [31:0] range_high,
    input  logic [63:0] lcg_multiplier,
    input  logic [63:0] lcg_increment,
    input  logic [63:0] seed_value,
    output logic [31:0] random_value
);

    // XSH-RR output permutation of a 64-bit state
    function automatic logic [31:0] xsh_rr(input logic [63:0] s);
        logic [63:0] t;
        logic [63:0] xx;
        t  = (s >> 18) ^ s;
        xx = {t[58:27], t[58:27]} >> s[63:59];
        return xx[31:0];
    endfunction

    logic [63:0] state_reg;
    logic [63:0] acc_reg;
    logic [63:0] prod_reg;
    op_t         op_reg;
    logic [31:0] lo_reg;
    logic [31:0] hi_reg;
    logic [31:0] bound_reg;
    logic [31:0] r_reg;
    logic [31:0] floor_reg;
    logic [31:0] random_value_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] div_dividend;
    logic [31:0] div_rem;
    logic        div_busy;
    logic        div_done;

    // Generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else
        begin
            case (cmd.st_op)
                SOP_ZERO:     state_reg <= '0;
                SOP_ADD_SEED: state_reg <= state_reg + seed_value;
                SOP_LOAD_ACC: state_reg <= acc_reg;
                default:      state_reg <= state_reg;
            endcase
        end
    end

    // Partial product operand select
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_LL:
            begin
                mul_a = state_reg[31:0];
                mul_b = lcg_multiplier[31:0];
            end
            MUL_LH:
            begin
                mul_a = state_reg[31:0];
                mul_b = lcg_multiplier[63:32];
            end
            MUL_HL:
            begin
                mul_a = state_reg[63:32];
                mul_b = lcg_multiplier[31:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Registered 32x32 product, then accumulate into the next state
    always_ff @(posedge clk)
    begin
        if (cmd.mul_sel != MUL_NONE)
            prod_reg <= mul_a * mul_b;
        case (cmd.acc_op)
            ACC_INIT:   acc_reg <= prod_reg + lcg_increment;
            ACC_ADD_HI: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            default:    acc_reg <= acc_reg;
        endcase
    end

    // Transaction capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= op_t'(operation);
            lo_reg <= range_low;
            hi_reg <= range_high;
            if (op_t'(operation) == OP_BOUNDED)
                bound_reg <= range_high;
            else
                bound_reg <= range_high - range_low + 32'd1;
        end
    end

    // Draw output and rejection threshold
    always_ff @(posedge clk)
    begin
        if (cmd.capture_r)
            r_reg <= xsh_rr(state_reg);
        if (cmd.load_floor)
            floor_reg <= div_rem;
    end

    // Shared divider: threshold (2^32 - bound) mod bound, then draw mod bound
    assign div_dividend = (cmd.div_src == DIV_FLOOR) ? (32'd0 - bound_reg) : r_reg;

    prb_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (bound_reg),
        .busy      (div_busy),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            case (cmd.out_sel)
                OUT_RAW: random_value_reg <= r_reg;
                OUT_LOW: random_value_reg <= lo_reg;
                OUT_REM: random_value_reg <= div_rem +
                                             ((op_reg == OP_INTERVAL) ? lo_reg : 32'd0);
                default: random_value_reg <= '0;
            endcase
        end
    end

    assign random_value = random_value_reg;

    // Status toward the controller
    always_comb
    begin
        status.op             = op_reg;
        status.bound_zero     = (bound_reg == '0);
        status.interval_empty = (lo_reg >= hi_reg);
        status.reject         = (r_reg < floor_reg);
        status.div_busy       = div_busy;
        status.div_done       = div_done;
    end

endmodule

@@ rtl/prb_ctrl.sv @@
module prb_ctrl
    import prb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output cmd_t    cmd,
    input  status_t status
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    out_sel_t    out_sel_reg;
    out_sel_t    out_sel_next;
    logic [5:0]  tries_reg;
    logic [5:0]  tries_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_RAW;
            out_sel_reg   <= OUT_ZERO;
            tries_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_sel_reg   <= out_sel_next;
            tries_reg     <= tries_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        out_sel_next = out_sel_reg;
        tries_next   = tries_reg;
        cmd          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                case (status.op)
                    OP_RESTART:
                    begin
                        cmd.st_op  = SOP_ZERO;
                        phase_next = PH_RST1;
                        state_next = S_ADV0;
                    end
                    OP_RAW:
                    begin
                        phase_next = PH_RAW;
                        state_next = S_ADV0;
                    end
                    OP_BOUNDED:
                    begin
                        if (status.bound_zero)
                        begin
                            out_sel_next = OUT_ZERO;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_src   = DIV_FLOOR;
                            state_next    = S_FLOOR_WAIT;
                        end
                    end
                    default:
                    begin
                        // empty, reversed or full-width interval gives the low end
                        if (status.interval_empty || status.bound_zero)
                        begin
                            out_sel_next = OUT_LOW;
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            cmd.div_src   = DIV_FLOOR;
                            state_next    = S_FLOOR_WAIT;
                        end
                    end
                endcase
            end

            S_SEED:
            begin
                cmd.st_op  = SOP_ADD_SEED;
                phase_next = PH_RST2;
                state_next = S_ADV0;
            end

            // State advance: three partial products, accumulated and loaded into the state
            S_ADV0:
            begin
                cmd.capture_r = 1'b1;
                cmd.mul_sel   = MUL_LL;
                state_next    = S_ADV1;
            end
            S_ADV1:
            begin
                cmd.acc_op  = ACC_INIT;
                cmd.mul_sel = MUL_LH;
                state_next  = S_ADV2;
            end
            S_ADV2:
            begin
                cmd.acc_op  = ACC_ADD_HI;
                cmd.mul_sel = MUL_HL;
                state_next  = S_ADV3;
            end
            S_ADV3:
            begin
                cmd.acc_op = ACC_ADD_HI;
                state_next = S_ADV4;
            end
            S_ADV4:
            begin
                cmd.st_op = SOP_LOAD_ACC;
                case (phase_reg)
                    PH_RST1:
                    begin
                        state_next = S_SEED;
                    end
                    PH_RST2:
                    begin
                        out_sel_next = OUT_ZERO;
                        state_next   = S_FINISH;
                    end
                    PH_RAW:
                    begin
                        out_sel_next = OUT_RAW;
                        state_next   = S_FINISH;
                    end
                    default:
                    begin
                        state_next = S_CHECK;
                    end
                endcase
            end

            S_FLOOR_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.load_floor = 1'b1;
                    tries_next     = '0;
                    phase_next     = PH_DRAW;
                    state_next     = S_ADV0;
                end
            end

            // Rejection sampling: retry below the threshold, up to the try limit
            S_CHECK:
            begin
                if (status.reject && (tries_reg != TRY_LAST))
                begin
                    tries_next = tries_reg + 6'd1;
                    state_next = S_ADV0;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = DIV_DRAW;
                    state_next    = S_MOD_WAIT;
                end
            end

            S_MOD_WAIT:
            begin
                if (status.div_done)
                begin
                    out_sel_next = OUT_REM;
                    state_next   = S_FINISH;
                end
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = out_sel_reg;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("second transaction accepted while one is in progress");

    a_div_not_restarted: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FINISH))
        else $error("result presented outside the finish step");

endmodule

@@ verif/pcg32_bounded_random_source_test.sv @@
`timescale 1ns / 100ps

import prb_pkg::*;

// Tracks the generator state and the queue of draws still owed by the block
class draw_scoreboard;
    logic [63:0] multiplier;
    logic [63:0] increment;
    logic [63:0] seed;
    logic [63:0] gen_state;
    logic [31:0] pending_draws[$];
    int unsigned mismatches;
    int unsigned draws_checked;
    int unsigned op_seen[4];

    function new();
        multiplier = MULT_RESET;
        increment  = INC_RESET;
        seed       = SEED_RESET;
        mismatches = 0;
        draws_checked = 0;
        foreach (op_seen[i])
            op_seen[i] = 0;
        reseed();
    endfunction

    function void set_reg(logic [1:0] idx, logic [63:0] value);
        case (idx)
            CFG_MULT: multiplier = value;
            CFG_INC:  increment  = value;
            CFG_SEED: seed       = value;
            default: ;
        endcase
    endfunction

    // One LCG step; output is the XSH-RR permutation of the old state
    function logic [31:0] next_draw();
        logic [63:0] s;
        logic [31:0] x;
        logic [4:0]  rot;
        logic [63:0] twice;
        s = gen_state;
        gen_state = s * multiplier + increment;
        x = 32'(((s >> 18) ^ s) >> 27);
        rot = s[63:59];
        twice = {x, x} >> rot;
        return twice[31:0];
    endfunction

    // Seeding sequence: zero, step, add seed, step
    function void reseed();
        logic [31:0] unused;
        gen_state = 64'd0;
        unused = next_draw();
        gen_state = gen_state + seed;
        unused = next_draw();
    endfunction

    // Rejection sampling, at most 64 tries; zero bound gives 0 without a step
    function logic [31:0] bounded_draw(logic [31:0] bound);
        logic [31:0] neg;
        logic [31:0] reject_below;
        logic [31:0] r;
        int k;
        if (bound == 32'd0)
            return 32'd0;
        neg = 32'd0 - bound;
        reject_below = neg % bound;
        r = 32'd0;
        for (k = 0; k < 64; k++)
        begin
            r = next_draw();
            if (r >= reject_below)
                break;
        end
        return r % bound;
    endfunction

    function void note_request(op_t op, logic [31:0] lo, logic [31:0] hi);
        logic [31:0] v;
        op_seen[op]++;
        case (op)
            OP_RESTART:
            begin
                reseed();
                v = 32'd0;
            end
            OP_RAW:     v = next_draw();
            OP_BOUNDED: v = bounded_draw(hi);
            default:
            begin
                if (lo >= hi)
                    v = lo;
                else
                    v = lo + bounded_draw(hi - lo + 32'd1);
            end
        endcase
        pending_draws = {pending_draws, v};
    endfunction

    function void check_draw(logic [31:0] actual);
        logic [31:0] expected;
        draws_checked++;
        if (pending_draws.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected random_value %h with nothing pending", actual);
            return;
        end
        expected = pending_draws.pop_front();
        if (actual !== expected)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: draw %0d random_value expected %h actual %h",
                         draws_checked, expected, actual);
        end
    endfunction

    function int unsigned pending();
        return pending_draws.size();
    endfunction
endclass

module pcg32_bounded_random_source_test;
    import prb_pkg::*;

    localparam int unsigned IDLE_LIMIT = 5000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            operation = OP_RAW;
    logic [31:0]           range_low = 32'd0;
    logic [31:0]           range_high = 32'd0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [31:0]           random_value;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [63:0]           pwdata = 64'd0;
    logic [63:0]           prdata;
    logic                  pready;

    draw_scoreboard sb;
    int unsigned idle_cycles = 0;
    int unsigned settings_used = 1;

    pcg32_bounded_random_source dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .range_low    (range_low),
        .range_high   (range_high),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .random_value (random_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #5 clk = ~clk;

    // Result side: check every accepted transaction
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_draw(random_value);
        end
    end

    // Receiver stall pattern: short bursts, occasional long stalls and long free runs
    initial
    begin
        int unsigned free_len;
        int unsigned stall_len;
        forever
        begin
            free_len = ($urandom_range(0, 99) < 3) ? $urandom_range(200, 400)
                                                   : $urandom_range(1, 12);
            repeat (free_len)
            begin
                @(negedge clk);
                out_stall <= 1'b0;
            end
            stall_len = ($urandom_range(0, 99) < 10) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 3);
            repeat (stall_len)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'd1;
            2: return $urandom_range(2, 16);
            3: return 32'd1 << $urandom_range(0, 31);
            4: return 32'h8000_0000 + $urandom_range(1, 255);
            5: return 32'hFFFF_FFFF - $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    // Input side: optional gap with noise on the fields, then hold until accepted
    task automatic send_request(op_t op, logic [31:0] lo, logic [31:0] hi, int unsigned gap);
        if (gap != 0)
        begin
            repeat (gap)
            begin
                @(negedge clk);
                in_valid   <= 1'b0;
                operation  <= 2'($urandom);
                range_low  <= $urandom;
                range_high <= $urandom;
            end
        end
        @(negedge clk);
        in_valid   <= 1'b1;
        operation  <= op;
        range_low  <= lo;
        range_high <= hi;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(op, lo, hi);
    endtask

    // Drop valid right after the last accept, then wait for all owed draws
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    // Write one register, then read it back while the address still selects it
    task automatic write_reg(logic [1:0] idx, logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        if (prdata !== value)
        begin
            sb.mismatches++;
            if (sb.mismatches <= 10)
                $display("ERROR: register %0d read back %h, written %h", idx, prdata, value);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(logic [63:0] mult, logic [63:0] inc, logic [63:0] seed);
        wait_for_drain();
        repeat (4) @(posedge clk);
        write_reg(CFG_MULT, mult);
        write_reg(CFG_INC, inc);
        write_reg(CFG_SEED, seed);
        settings_used++;
    endtask

    // Field extremes, each operation and the corner cases of bounds and intervals
    task automatic run_directed();
        send_request(OP_RAW, 32'd0, 32'd0, pick_gap());
        send_request(OP_RESTART, '1, '1, pick_gap());
        send_request(OP_RAW, '1, '1, pick_gap());
        send_request(OP_BOUNDED, 32'd0, 32'd0, pick_gap());
        send_request(OP_BOUNDED, '1, 32'd1, pick_gap());
        send_request(OP_BOUNDED, 32'd0, '1, pick_gap());
        send_request(OP_BOUNDED, 32'd0, 32'h8000_0001, pick_gap());
        send_request(OP_BOUNDED, 32'd0, 32'h8000_0000, pick_gap());
        send_request(OP_BOUNDED, 32'd0, 32'd7, pick_gap());
        // full interval wraps the span to zero
        send_request(OP_INTERVAL, 32'd0, '1, pick_gap());
        send_request(OP_INTERVAL, 32'd5, 32'd5, pick_gap());
        send_request(OP_INTERVAL, '1, 32'd0, pick_gap());
        send_request(OP_INTERVAL, 32'hFFFF_FFFE, '1, pick_gap());
        send_request(OP_INTERVAL, 32'd0, 32'd1, pick_gap());
        send_request(OP_INTERVAL, 32'd1, '1, pick_gap());
        send_request(OP_INTERVAL, 32'd100, 32'd200, pick_gap());
        send_request(OP_RESTART, 32'd0, 32'd0, pick_gap());
        send_request(OP_RAW, 32'd0, 32'd0, pick_gap());
    endtask

    task automatic run_random(int unsigned count);
        op_t         op;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tmp;
        int unsigned sel;
        int unsigned gap;
        for (int unsigned n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            op = (sel < 10) ? OP_RESTART : (sel < 35) ? OP_RAW :
                 (sel < 70) ? OP_BOUNDED : OP_INTERVAL;
            lo = $urandom;
            hi = pick_bound();
            if (op == OP_INTERVAL)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        // empty or reversed
                        if (lo < hi)
                        begin
                            tmp = lo;
                            lo = hi;
                            hi = tmp;
                        end
                    end
                    1:
                    begin
                        lo = 32'd0;
                        hi = '1;
                    end
                    2:
                    begin
                        lo = $urandom_range(0, 32'hFFFF_FF00);
                        hi = lo + $urandom_range(1, 64);
                    end
                    3:
                    begin
                        lo = $urandom_range(0, 255);
                        hi = 32'hFFFF_FFFF - $urandom_range(0, 255);
                    end
                    default: hi = $urandom;
                endcase
            end
            gap = ((n % 100) < 25) ? 0 : pick_gap();
            // sender holds off until the block has delivered everything
            if (n == count / 2 || $urandom_range(0, 99) == 0)
                wait_for_drain();
            send_request(op, lo, hi, gap);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings
        run_directed();
        run_random(250);
        // all-zero registers: state sticks at zero; nonzero thresholds reject to the limit
        apply_config(64'd0, 64'd0, 64'd0);
        run_random(40);
        apply_config('1, '1, '1);
        run_random(120);
        apply_config(64'd1, 64'd0, {$urandom, $urandom});
        run_random(60);
        apply_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        run_random(200);
        apply_config(MULT_RESET, INC_RESET, {$urandom, $urandom});
        run_random(200);
        // odd random multiplier, no increment
        apply_config({$urandom, $urandom} | 64'd1, 64'd0, '1);
        run_random(130);

        wait_for_drain();
        repeat (100) @(posedge clk);
        if (sb.pending() != 0)
        begin
            sb.mismatches++;
            $display("ERROR: %0d draws never arrived", sb.pending());
        end

        $display("Sent %0d restarts, %0d raw, %0d bounded and %0d interval draws",
                 sb.op_seen[OP_RESTART], sb.op_seen[OP_RAW],
                 sb.op_seen[OP_BOUNDED], sb.op_seen[OP_INTERVAL]);
        $display("Checked %0d results over %0d register settings, %0d mismatches",
                 sb.draws_checked, settings_used, sb.mismatches);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
